// File: design/lir_pkg.sv
`timescale 1ns / 1ps

package lir_pkg;

    // Field and arithmetic widths
    localparam int SMP_W   = 16;               // PCM sample width
    localparam int FRAC_W  = 16;               // fractional bits of the phase
    localparam int RATIO_W = 21;               // ratio register width, Q16
    localparam int PHASE_W = 21;               // phase accumulator width
    localparam int DIFF_W  = SMP_W + 1;        // cur - prev
    localparam int PROD_W  = DIFF_W + FRAC_W + 1;
    localparam int MAX_RES = 64;               // most results per input item
    localparam int CNT_W   = $clog2(MAX_RES) + 1;

    localparam logic [PHASE_W-1:0] PH_ONE    = PHASE_W'(1) << FRAC_W;
    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRAC_W;
    localparam logic [RATIO_W-1:0] RATIO_MIN = RATIO_ONE >> 5;
    localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_ONE << 4;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_L1,
        S_G1,
        S_L2CHK,
        S_G2,
        S_END
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic cap;      // capture the input item
        logic mul;      // register (cur - prev) * phase
        logic gen;      // form a result into the pending stage, advance phase
        logic byp;      // pending stage takes the input sample as is
        logic wrap;     // end of the interval: wrap phase, prev takes cur
        logic first;    // first sample of a buffer: phase to 0, prev takes cur
        logic flush;    // move the pending result out as the item's last
        logic clr;      // return interpolation state to reset values
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic have_prev;
        logic bypass;     // ratio is exactly 1.0
        logic more;       // another output position lies in this interval, within the result limit
        logic last;       // captured item ends a buffer
        logic pend_valid;
        logic out_free;   // output register can take a result this cycle
    } t_stat;

endpackage

// File: design/lir_ctrl.sv
`timescale 1ns / 1ps

module lir_ctrl
    import lir_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // pending stage may be refilled once its old content can leave
    logic w_slot;
    assign w_slot = !i_stat.pend_valid || i_stat.out_free;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_START;
            end
            S_START: begin
                if (i_stat.bypass)         n_state = S_END;
                else if (i_stat.have_prev) n_state = S_L1;
                else                       n_state = S_L2CHK;
            end
            S_L1: begin
                n_state = i_stat.more ? S_G1 : S_L2CHK;
            end
            S_G1: begin
                if (w_slot) n_state = S_L1;
            end
            S_L2CHK: begin
                n_state = (i_stat.last && i_stat.more) ? S_G2 : S_END;
            end
            S_G2: begin
                if (w_slot) n_state = S_L2CHK;
            end
            S_END: begin
                if (w_slot) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.cap  = i_in_valid;
            end
            S_START: begin
                if (i_stat.bypass)          o_cmd.byp   = 1'b1;
                else if (!i_stat.have_prev) o_cmd.first = 1'b1;
            end
            S_L1: begin
                if (i_stat.more) o_cmd.mul  = 1'b1;
                else             o_cmd.wrap = 1'b1;
            end
            S_G1: begin
                o_cmd.gen = w_slot;
            end
            S_L2CHK: begin
                o_cmd.mul = i_stat.last && i_stat.more;
            end
            S_G2: begin
                o_cmd.gen = w_slot;
            end
            S_END: begin
                if (w_slot) begin
                    o_cmd.flush = i_stat.pend_valid;
                    o_cmd.clr   = i_stat.last || i_stat.bypass;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: design/lir_datapath.sv
`timescale 1ns / 1ps

module lir_datapath
    import lir_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic                     i_cfg_we,
    input  logic [RATIO_W-1:0]       i_cfg_wdata,
    input  logic signed [SMP_W-1:0]  i_in_sample,
    input  logic                     i_in_end,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [SMP_W-1:0]  o_out_sample,
    output logic                     o_out_run_last,
    output logic                     o_out_done
);

    logic [RATIO_W-1:0]       r_ratio;
    logic signed [SMP_W-1:0]  r_cur;
    logic                     r_last;
    logic signed [SMP_W-1:0]  r_prev;
    logic                     r_have_prev;
    logic [PHASE_W-1:0]       r_phase;
    logic [CNT_W-1:0]         r_count;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SMP_W-1:0]  r_pend;
    logic                     r_pend_valid;
    logic                     r_out_valid;
    logic signed [SMP_W-1:0]  r_out_sample;
    logic                     r_out_run_last;
    logic                     r_out_done;

    // Ratio clamped to the supported range
    logic [RATIO_W-1:0] w_step;
    always_comb begin
        if (r_ratio < RATIO_MIN)      w_step = RATIO_MIN;
        else if (r_ratio > RATIO_MAX) w_step = RATIO_MAX;
        else                          w_step = r_ratio;
    end

    // Multiplier operands: difference and fractional phase
    logic signed [DIFF_W-1:0]   w_diff;
    logic signed [FRAC_W:0]     w_frac;
    assign w_diff = DIFF_W'(r_cur) - DIFF_W'(r_prev);
    assign w_frac = $signed({1'b0, r_phase[FRAC_W-1:0]});

    // Interpolated value: prev plus the product shifted down (floor)
    logic signed [PROD_W-1:0] w_q;
    logic signed [PROD_W-1:0] w_sum;
    logic signed [SMP_W-1:0]  w_val;
    assign w_q   = r_prod >>> FRAC_W;
    assign w_sum = PROD_W'(r_prev) + w_q;
    assign w_val = w_sum[SMP_W-1:0];

    logic w_out_free;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Status towards the controller
    always_comb begin
        o_stat.have_prev  = r_have_prev;
        o_stat.bypass     = (r_ratio == RATIO_ONE);
        o_stat.more       = (r_phase < PH_ONE) && (r_count < CNT_W'(MAX_RES));
        o_stat.last       = r_last;
        o_stat.pend_valid = r_pend_valid;
        o_stat.out_free   = w_out_free;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= RATIO_ONE;
        end else if (i_cfg_we) begin
            r_ratio <= i_cfg_wdata;
        end
    end

    // Input capture and product register
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_cur  <= i_in_sample;
            r_last <= i_in_end;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(w_diff) * PROD_W'(w_frac);
        end
    end

    // Interpolation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_phase     <= '0;
            r_count     <= '0;
        end else begin
            if (i_cmd.cap) begin
                r_count <= '0;
            end
            if (i_cmd.gen) begin
                r_phase <= r_phase + PHASE_W'(w_step);
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.wrap) begin
                // count limit can stop the loop short of the interval end
                r_phase     <= (r_phase >= PH_ONE) ? (r_phase - PH_ONE) : '0;
                r_prev      <= r_cur;
                r_have_prev <= 1'b1;
            end
            if (i_cmd.first) begin
                r_phase     <= '0;
                r_prev      <= r_cur;
                r_have_prev <= 1'b1;
            end
            if (i_cmd.clr) begin
                r_prev      <= '0;
                r_have_prev <= 1'b0;
                r_phase     <= '0;
            end
        end
    end

    // Pending stage: holds a result until it is known whether another follows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cmd.gen || i_cmd.byp) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
        end
        if (i_cmd.gen) begin
            r_pend <= w_val;
        end else if (i_cmd.byp) begin
            r_pend <= r_cur;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.gen && r_pend_valid) || i_cmd.flush) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.gen && r_pend_valid) begin
            r_out_sample   <= r_pend;
            r_out_run_last <= 1'b0;
            r_out_done     <= 1'b0;
        end else if (i_cmd.flush) begin
            r_out_sample   <= r_pend;
            r_out_run_last <= 1'b1;
            r_out_done     <= r_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_sample   = r_out_sample;
    assign o_out_run_last = r_out_run_last;
    assign o_out_done     = r_out_done;

endmodule

// File: design/linear_interp_resampler.sv
`timescale 1ns / 1ps
// Channel     Direction  Ports            Contents
// s_axis      in         tdata, tlast     sample_in / buffer_end
// m_axis      out        tdata, tuser,    sample_out / run_last / buffer_done
//                        tlast
// cfg         in         we, wdata        ratio_step, unsigned Q16
//
// Without stalls each interpolated result passes through the shared multiplier
// register and then the pending stage; a bypass result goes straight to the
// pending stage.
// The input is taken only when the sequencer is idle; the last result may
// still sit in the output register while the next item is accepted.
// A stalled output holds the sequencer at the pending stage.
// Reset is synchronous, active low; ratio_step returns to 1.0 (bypass).

module linear_interp_resampler
    import lir_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [RATIO_W-1:0] i_cfg_wdata,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [15:0]        i_s_axis_tdata,   // [15:0] sample_in
    input  logic               i_s_axis_tlast,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [15:0]        o_m_axis_tdata,   // [15:0] sample_out
    output logic               o_m_axis_tuser,   // [0] run_last
    output logic               o_m_axis_tlast
);

    t_cmd                    w_cmd;
    t_stat                   w_stat;
    logic signed [SMP_W-1:0] w_out_sample;

    lir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_stat     (w_stat),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    lir_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_sample    ($signed(i_s_axis_tdata[SMP_W-1:0])),
        .i_in_end       (i_s_axis_tlast),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_out_sample   (w_out_sample),
        .o_out_run_last (o_m_axis_tuser),
        .o_out_done     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = w_out_sample;

endmodule

// File: design/lir_checker.sv
`timescale 1ns / 1ps

module lir_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // stalled result holds its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) &&
            $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("output changed while stalled");

    // buffer end is only ever flagged on the last result of an item
    a_done_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser)
        else $error("buffer_done without run_last");

    // one item at a time: no input taken in the cycle after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // reset leaves the block idle with nothing to deliver
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("not idle after reset");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// File: dv/tb_linear_interp_resampler.sv
`timescale 1ns / 1ps

module tb_linear_interp_resampler;
    import lir_pkg::*;

    localparam int RAND_ITEMS = 200;
    localparam int SETTLE_CYC = 150;   // wait after a drained block so the sequencer can go idle

    typedef struct packed {
        logic signed [SMP_W-1:0] smp;
        logic                    last;
    } src_item_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] smp;
        logic                    run_last;
        logic                    done;
    } pcm_out_t;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_we        = 1'b0;
    logic [RATIO_W-1:0] i_cfg_wdata     = '0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [15:0]        i_s_axis_tdata  = '0;   // [15:0] sample_in
    logic               i_s_axis_tlast  = 1'b0;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [15:0]        o_m_axis_tdata;         // [15:0] sample_out
    logic               o_m_axis_tuser;         // [0] run_last
    logic               o_m_axis_tlast;

    // Source items waiting for the bus, and results the converter still owes
    src_item_t src_q[$];
    pcm_out_t  owed_pcm[$];

    int unsigned src_idle_pct = 10;
    int unsigned snk_stall_pct = 69;
    int          mismatch_cnt = 0;

    // Converter state as predicted
    logic [RATIO_W-1:0]      ratio_q   = RATIO_ONE;
    logic signed [SMP_W-1:0] prev_q    = '0;
    logic                    have_prev = 1'b0;
    int unsigned             phase_q   = 0;

    linear_interp_resampler u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Work out the output samples one source sample produces
    task automatic predict_resample(input logic signed [SMP_W-1:0] cur, input logic last);
        pcm_out_t    batch[$];
        pcm_out_t    res;
        int unsigned r;
        longint      prod;
        int          n;
        r = ratio_q;
        n = 0;
        if (ratio_q == RATIO_ONE) begin
            // unity ratio: straight through, any interpolation dropped
            res.smp = cur;
            res.run_last = 1'b1;
            res.done = last;
            owed_pcm.push_back(res);
            prev_q = '0;
            have_prev = 1'b0;
            phase_q = 0;
            return;
        end
        if (r < RATIO_MIN) r = RATIO_MIN;
        if (r > RATIO_MAX) r = RATIO_MAX;
        if (have_prev) begin
            while (phase_q < PH_ONE && n < MAX_RES) begin
                prod = (longint'(cur) - longint'(prev_q)) * longint'(phase_q);
                res.smp = SMP_W'(longint'(prev_q) + (prod >>> FRAC_W));
                res.run_last = 1'b0;
                res.done = 1'b0;
                batch.push_back(res);
                n++;
                phase_q += r;
            end
            if (phase_q >= PH_ONE) phase_q -= PH_ONE;
            else phase_q = 0;
        end else begin
            phase_q = 0;
        end
        prev_q = cur;
        have_prev = 1'b1;
        if (last) begin
            // final interval of the buffer is held at the last sample
            while (phase_q < PH_ONE && n < MAX_RES) begin
                res.smp = cur;
                res.run_last = 1'b0;
                res.done = 1'b0;
                batch.push_back(res);
                n++;
                phase_q += r;
            end
            if (n > 0) batch[n-1].done = 1'b1;
            prev_q = '0;
            have_prev = 1'b0;
            phase_q = 0;
        end
        if (n > 0) batch[n-1].run_last = 1'b1;
        foreach (batch[i]) owed_pcm.push_back(batch[i]);
    endtask

    // Source driver: predicts on each accepted transfer, then offers the next item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (i_s_axis_tvalid)
                predict_resample($signed(i_s_axis_tdata), i_s_axis_tlast);
            if (src_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= src_q[0].smp;
                i_s_axis_tlast  <= src_q[0].last;
                void'(src_q.pop_front());
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor and random back-pressure
    pcm_out_t want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (owed_pcm.size() == 0) begin
                $display("%0t: unexpected result smp=%0d run_last=%0b done=%0b", $time,
                         $signed(o_m_axis_tdata), o_m_axis_tuser, o_m_axis_tlast);
                mismatch_cnt++;
            end else begin
                want = owed_pcm.pop_front();
                if (o_m_axis_tdata !== want.smp) begin
                    $display("%0t: sample_out exp %0d got %0d", $time, want.smp,
                             $signed(o_m_axis_tdata));
                    mismatch_cnt++;
                end
                if (o_m_axis_tuser !== want.run_last) begin
                    $display("%0t: run_last exp %0b got %0b", $time, want.run_last,
                             o_m_axis_tuser);
                    mismatch_cnt++;
                end
                if (o_m_axis_tlast !== want.done) begin
                    $display("%0t: buffer_done exp %0b got %0b", $time, want.done,
                             o_m_axis_tlast);
                    mismatch_cnt++;
                end
            end
        end
        i_m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic push_item(input logic signed [SMP_W-1:0] smp, input logic last);
        src_item_t it;
        it.smp = smp;
        it.last = last;
        src_q.push_back(it);
    endtask

    // Hold the source until every owed result is in and the sequencer has gone idle
    task automatic drain_block();
        while (src_q.size() > 0 || i_s_axis_tvalid || owed_pcm.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_ratio(input logic [RATIO_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        ratio_q = val;
    endtask

    // Stimulus
    initial begin
        int          n_gen;
        int          len;
        logic [15:0] smp;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unity ratio after reset, field extremes
        push_item(16'sd32767, 1'b0);
        push_item(-16'sd32768, 1'b1);
        push_item(16'sd0, 1'b0);
        drain_block();

        // half ratio, full-scale swings both ways, then a one-sample buffer
        write_ratio(21'd32768);
        push_item(-16'sd32768, 1'b0);
        push_item(16'sd32767, 1'b0);
        push_item(-16'sd32768, 1'b0);
        push_item(16'sd5, 1'b1);
        push_item(16'sd1234, 1'b1);
        drain_block();

        // ratio 4.0: last sample of the buffer yields nothing
        write_ratio(21'd262144);
        push_item(16'sd100, 1'b0);
        push_item(16'sd200, 1'b0);
        push_item(16'sd300, 1'b1);
        drain_block();

        // below the minimum: clamped to 1/32, full result count
        write_ratio('0);
        push_item(-16'sd32768, 1'b0);
        push_item(16'sd32767, 1'b1);
        drain_block();

        // above the maximum: clamped to 16.0
        write_ratio('1);
        push_item(16'sd7, 1'b0);
        push_item(-16'sd7, 1'b0);
        push_item(16'sd9, 1'b1);
        drain_block();

        // ratio change in the middle of a buffer
        write_ratio(21'd40000);
        push_item(16'sd1000, 1'b0);
        push_item(-16'sd1000, 1'b0);
        drain_block();
        write_ratio(21'd90000);
        push_item(16'sd2000, 1'b0);
        push_item(-16'sd3000, 1'b1);
        drain_block();

        // unity ratio in the middle of a buffer drops the interpolation
        write_ratio(21'd20000);
        push_item(16'sd10, 1'b0);
        push_item(16'sd20, 1'b0);
        drain_block();
        write_ratio(RATIO_ONE);
        push_item(16'sd30, 1'b0);
        drain_block();
        write_ratio(21'd30000);
        push_item(16'sd40, 1'b0);
        push_item(16'sd50, 1'b1);
        drain_block();

        // random phases; each ends with the source held until all results are in
        n_gen = 0;
        while (n_gen < RAND_ITEMS) begin
            if (n_gen < RAND_ITEMS / 3) begin
                src_idle_pct = 10;
                snk_stall_pct = 69;
            end else if (n_gen < 2 * RAND_ITEMS / 3) begin
                src_idle_pct = 69;
                snk_stall_pct = 10;
            end else begin
                src_idle_pct = 0;
                snk_stall_pct = 0;
            end
            // a quarter of the phases keep the ratio and carry the buffer on
            if ($urandom_range(3) != 0) begin
                case ($urandom_range(9))
                    0:       write_ratio(RATIO_ONE);
                    1:       write_ratio(RATIO_W'($urandom_range(0, RATIO_MIN - 1)));
                    2:       write_ratio(RATIO_W'($urandom_range(RATIO_MAX + 1, (1 << RATIO_W) - 1)));
                    3:       write_ratio(RATIO_MIN);
                    4:       write_ratio(RATIO_MAX);
                    5:       write_ratio(RATIO_W'($urandom_range(RATIO_ONE - 1, RATIO_ONE + 1)));
                    6:       write_ratio(RATIO_W'($urandom_range(RATIO_ONE, RATIO_MAX)));
                    default: write_ratio(RATIO_W'($urandom_range(RATIO_MIN, 3 * RATIO_ONE)));
                endcase
            end
            len = $urandom_range(8, 24);
            repeat (len) begin
                case ($urandom_range(7))
                    0:       smp = 16'h8000;
                    1:       smp = 16'h7fff;
                    default: smp = 16'($urandom_range(0, 16'hffff));
                endcase
                push_item($signed(smp), ($urandom_range(3) == 0));
            end
            n_gen += len;
            drain_block();
        end

        if (mismatch_cnt == 0 && owed_pcm.size() == 0) begin
            $display("[linear_interp_resampler] OK");
        end else begin
            $display("[linear_interp_resampler] ERROR");
        end
        $finish;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("[linear_interp_resampler] ERROR");
        $finish;
    end

endmodule
